// ===== src/wfr_pkg.sv =====
package wfr_pkg;

  // Default message buffer size in bytes.
  localparam int MESSAGE_CAPACITY_DEF = 4096;

  // Fixed widths of the result offsets and sizes (OUT_W) and of the input length fields (LEN_W).
  localparam int OUT_W = 13;
  localparam int LEN_W = 31;

  localparam logic       OP_PUSH  = 1'b0;
  localparam logic       OP_RESET = 1'b1;

  localparam logic [7:0] KIND_CONTINUATION = 8'h00;
  localparam logic [7:0] KIND_BINARY       = 8'h02;

  typedef enum logic [1:0] {
    ST_REJECTED = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_COMPLETE = 2'd2
  } wfr_status_t;

  typedef struct packed {
    logic             opcode;
    logic [7:0]       frame_type;
    logic             fin;
    logic [LEN_W-1:0] frame_len;
    logic [LEN_W-1:0] chunk_off;
    logic [LEN_W-1:0] chunk_length;
    logic             data_present;
    logic             allow_first_continuation;
  } wfr_item_t;

  // Frame and message flags.
  typedef struct packed {
    logic [7:0] frame_kind;
    logic       frame_last;
    logic       in_frame;
    logic       in_message;
    logic       first_ok;
  } wfr_ctl_t;

endpackage

// ===== src/websocket_fragment_reassembly_check.sv =====
// A beat is held in the input register, then its result in the result register.
// Throughput: one beat per cycle while out_stall is low; the check and the state
// update sit combinationally between the input register and the result register.
// Reset (rst_n low, synchronous): all frame/message state cleared, the
// first-continuation permission off, both pipeline registers empty.
module websocket_fragment_reassembly_check import wfr_pkg::*; #(
  parameter int MESSAGE_CAPACITY = MESSAGE_CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_opcode,
  input  logic [7:0]       in_frame_type,
  input  logic             in_fin,
  input  logic [LEN_W-1:0] in_frame_len,
  input  logic [LEN_W-1:0] in_chunk_off,
  input  logic [LEN_W-1:0] in_chunk_length,
  input  logic             in_data_present,
  input  logic             in_allow_first_continuation,

  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [OUT_W-1:0] out_write_offset,
  output logic [OUT_W-1:0] out_message_size
);

  // Byte counts never exceed the capacity, so they need only this many bits.
  localparam int SW = $clog2(MESSAGE_CAPACITY + 1);

  // Input register.
  logic        s1_valid_r, s1_valid_nxt;
  wfr_item_t   s1_item_r;

  // Connection state.
  wfr_ctl_t    ctl_r, ctl_nxt;
  logic [SW-1:0] gathered_r, gathered_nxt;
  logic [SW-1:0] progress_r, progress_nxt;
  logic [SW-1:0] total_r, total_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  wfr_status_t status_r;
  logic [SW-1:0] wr_r;
  logic [SW-1:0] size_r;

  wfr_status_t   chk_status;
  logic [SW-1:0] chk_wr;

  logic in_fire;
  logic advance;
  logic proc;
  logic push;

  // The result register frees up when empty or when its beat is taken;
  // the input register then hands its beat over.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;
  assign proc     = s1_valid_r && advance;
  assign push     = (s1_item_r.opcode == OP_PUSH);

  wfr_check #(
    .MESSAGE_CAPACITY (MESSAGE_CAPACITY),
    .SW               (SW)
  ) u_check (
    .item         (s1_item_r),
    .ctl          (ctl_r),
    .gathered     (gathered_r),
    .progress     (progress_r),
    .total        (total_r),
    .status       (chk_status),
    .wr_offset    (chk_wr),
    .ctl_nxt      (ctl_nxt),
    .gathered_nxt (gathered_nxt),
    .progress_nxt (progress_nxt),
    .total_nxt    (total_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    // a reset beat updates state but leaves no result
    if (advance) begin
      out_valid_nxt = proc && push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctl_r       <= '0;
      gathered_r  <= '0;
      progress_r  <= '0;
      total_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (proc) begin
        ctl_r      <= ctl_nxt;
        gathered_r <= gathered_nxt;
        progress_r <= progress_nxt;
        total_r    <= total_nxt;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.opcode                   <= in_opcode;
      s1_item_r.frame_type               <= in_frame_type;
      s1_item_r.fin                      <= in_fin;
      s1_item_r.frame_len                <= in_frame_len;
      s1_item_r.chunk_off                <= in_chunk_off;
      s1_item_r.chunk_length             <= in_chunk_length;
      s1_item_r.data_present             <= in_data_present;
      s1_item_r.allow_first_continuation <= in_allow_first_continuation;
    end
    if (proc && push) begin
      status_r <= chk_status;
      wr_r     <= chk_wr;
      size_r   <= gathered_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  // sizes are reported modulo the 13-bit field
  assign out_write_offset = OUT_W'(wr_r);
  assign out_message_size = OUT_W'(size_r);

  // A rejected beat reports zero offset and size.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_REJECTED)) |-> ((wr_r == '0) && (size_r == '0)))
    else $error("rejected result with nonzero offset or size");

  // The running size never falls behind the write position.
  a_size_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_REJECTED)) |-> (size_r >= wr_r))
    else $error("message size below write offset");

  // Gathered bytes stay within the buffer.
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    gathered_r <= SW'(MESSAGE_CAPACITY))
    else $error("gathered size beyond capacity");

  // Frame progress stays within the frame.
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    progress_r <= total_r)
    else $error("frame progress beyond frame length");

  // A frame in progress belongs to a message in progress.
  a_frame_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.in_frame |-> ctl_r.in_message)
    else $error("frame open outside a message");

endmodule

// ===== src/wfr_check.sv =====
module wfr_check import wfr_pkg::*; #(
  parameter int MESSAGE_CAPACITY = MESSAGE_CAPACITY_DEF,
  parameter int SW               = $clog2(MESSAGE_CAPACITY + 1)
) (
  input  wfr_item_t         item,
  input  wfr_ctl_t          ctl,
  input  logic [SW-1:0]     gathered,
  input  logic [SW-1:0]     progress,
  input  logic [SW-1:0]     total,
  output wfr_status_t       status,
  output logic [SW-1:0]     wr_offset,
  output wfr_ctl_t          ctl_nxt,
  output logic [SW-1:0]     gathered_nxt,
  output logic [SW-1:0]     progress_nxt,
  output logic [SW-1:0]     total_nxt
);

  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(MESSAGE_CAPACITY);

  logic             bad_data;
  logic             bad_bounds;
  logic             start;
  logic             bad_start;
  logic             bad_mid;
  logic             bad_ovf;
  logic [SW-1:0]    gath_eff;
  logic [SW-1:0]    chunk_s;
  logic [SW-1:0]    prog_new;
  logic [SW-1:0]    tot_new;
  logic             last_new;
  logic             done;
  logic [LEN_W-1:0] room;

  always_comb begin
    bad_data   = (item.chunk_length != '0) && !item.data_present;
    bad_bounds = (item.chunk_off > item.frame_len) ||
                 (item.chunk_length > (item.frame_len - item.chunk_off)) ||
                 (item.frame_len > CAP_L) ||
                 ((item.chunk_length == '0) && (item.chunk_off < item.frame_len));
    start      = (item.chunk_off == '0);

    bad_start  = ctl.in_frame ||
                 ((item.frame_type == KIND_BINARY) && ctl.in_message) ||
                 ((item.frame_type == KIND_CONTINUATION) && !ctl.in_message && !ctl.first_ok) ||
                 ((item.frame_type != KIND_BINARY) && (item.frame_type != KIND_CONTINUATION));
    bad_mid    = !ctl.in_frame ||
                 (item.chunk_off != LEN_W'(progress)) ||
                 (item.frame_len != LEN_W'(total)) ||
                 (item.frame_type != ctl.frame_kind) ||
                 (item.fin != ctl.frame_last);

    // a message start restarts the gathered count
    gath_eff   = (start && !ctl.in_message) ? '0 : gathered;

    room       = CAP_L - LEN_W'(gath_eff);
    bad_ovf    = item.chunk_length > room;

    chunk_s    = SW'(item.chunk_length);
    prog_new   = (start ? '0 : progress) + chunk_s;
    tot_new    = start ? SW'(item.frame_len) : total;
    last_new   = start ? item.fin : ctl.frame_last;
    done       = (prog_new == tot_new);

    ctl_nxt.frame_kind = start ? item.frame_type : ctl.frame_kind;
    ctl_nxt.frame_last = last_new;
    ctl_nxt.in_frame   = !done;
    ctl_nxt.in_message = !(done && last_new);
    ctl_nxt.first_ok   = (start && !ctl.in_message) ? 1'b0 : ctl.first_ok;
    gathered_nxt       = gath_eff + chunk_s;
    progress_nxt       = prog_new;
    total_nxt          = tot_new;
    wr_offset          = gath_eff;
    status             = (done && last_new) ? ST_COMPLETE : ST_ACCEPTED;

    if (item.opcode == OP_RESET) begin
      ctl_nxt          = '0;
      ctl_nxt.first_ok = item.allow_first_continuation;
      gathered_nxt     = '0;
      progress_nxt     = '0;
      total_nxt        = '0;
      wr_offset        = '0;
      status           = ST_REJECTED;
    end else if (bad_data || bad_bounds || (start ? bad_start : bad_mid) || bad_ovf) begin
      ctl_nxt      = '0;
      gathered_nxt = '0;
      progress_nxt = '0;
      total_nxt    = '0;
      wr_offset    = '0;
      status       = ST_REJECTED;
    end
  end

endmodule

// ===== dv/tb_websocket_fragment_reassembly_check.sv =====
module tb_websocket_fragment_reassembly_check;
  import wfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Message buffer size, as the DUT is built.
  localparam logic [31:0] CAPACITY = 32'd4096;
  // Cycles with no beat on either channel before the run is called hung.
  localparam int QUIET_LIMIT = 2000;

  // One expected result beat.
  typedef struct {
    wfr_status_t      status;
    logic [OUT_W-1:0] wr_offset;
    logic [OUT_W-1:0] msg_size;
  } verdict_t;

  logic             clk;
  logic             rst_n;

  logic             in_valid;
  logic             in_stall;
  logic             in_opcode;
  logic [7:0]       in_frame_type;
  logic             in_fin;
  logic [LEN_W-1:0] in_frame_len;
  logic [LEN_W-1:0] in_chunk_off;
  logic [LEN_W-1:0] in_chunk_length;
  logic             in_data_present;
  logic             in_allow_first_continuation;

  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_status;
  logic [OUT_W-1:0] out_write_offset;
  logic [OUT_W-1:0] out_message_size;

  // Idle percentages for the two sides, changed per phase.
  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned beats_sent;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  verdict_t pending_verdicts[$];

  // Shadow of the reassembly state.
  logic [OUT_W-1:0] msg_bytes;   // bytes gathered in the open message
  logic [OUT_W-1:0] frm_done;    // bytes of the open frame seen so far
  logic [OUT_W-1:0] frm_len;     // declared length of the open frame
  logic [7:0]       frm_kind;
  logic             frm_fin;
  logic             frm_open;
  logic             msg_open;
  logic             cont_ok;     // a continuation may open the next message

  websocket_fragment_reassembly_check DUT (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .in_valid                    (in_valid),
    .in_stall                    (in_stall),
    .in_opcode                   (in_opcode),
    .in_frame_type               (in_frame_type),
    .in_fin                      (in_fin),
    .in_frame_len                (in_frame_len),
    .in_chunk_off                (in_chunk_off),
    .in_chunk_length             (in_chunk_length),
    .in_data_present             (in_data_present),
    .in_allow_first_continuation (in_allow_first_continuation),
    .out_valid                   (out_valid),
    .out_stall                   (out_stall),
    .out_status                  (out_status),
    .out_write_offset            (out_write_offset),
    .out_message_size            (out_message_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------

  task automatic clear_shadow(input logic allow);
    msg_bytes = '0;
    frm_done  = '0;
    frm_len   = '0;
    frm_kind  = '0;
    frm_fin   = 1'b0;
    frm_open  = 1'b0;
    msg_open  = 1'b0;
    cont_ok   = allow;
  endtask

  // Applies one accepted beat to the shadow state and queues the result it
  // should produce. Reset beats only reload state.
  task automatic track_reassembly(input wfr_item_t it);
    logic [31:0] len;
    logic [31:0] off;
    logic [31:0] chk;
    logic        bad;
    verdict_t    v;
    len = {1'b0, it.frame_len};
    off = {1'b0, it.chunk_off};
    chk = {1'b0, it.chunk_length};
    if (it.opcode == OP_RESET) begin
      clear_shadow(it.allow_first_continuation);
      return;
    end
    bad = 1'b0;
    // null data with a nonzero length
    if (chk != 0 && !it.data_present) bad = 1'b1;
    // chunk bounds against the frame, frame against the buffer
    if (off > len || chk > len - off || len > CAPACITY || (chk == 0 && off < len))
      bad = 1'b1;
    if (!bad) begin
      if (off == 0) begin
        if (frm_open) begin
          bad = 1'b1;
        end else if (it.frame_type == KIND_BINARY) begin
          if (msg_open) begin
            bad = 1'b1;
          end else begin
            msg_bytes = '0;
            msg_open  = 1'b1;
            cont_ok   = 1'b0;
          end
        end else if (it.frame_type == KIND_CONTINUATION) begin
          if (!msg_open) begin
            if (!cont_ok) begin
              bad = 1'b1;
            end else begin
              msg_bytes = '0;
              msg_open  = 1'b1;
              cont_ok   = 1'b0;
            end
          end
        end else begin
          bad = 1'b1;
        end
        if (!bad) begin
          frm_open = 1'b1;
          frm_done = '0;
          frm_len  = len[OUT_W-1:0];
          frm_kind = it.frame_type;
          frm_fin  = it.fin;
        end
      end else if (!frm_open || off != frm_done || len != frm_len ||
                   it.frame_type != frm_kind || it.fin != frm_fin) begin
        bad = 1'b1;
      end
    end
    // message would overflow the buffer
    if (!bad && chk > CAPACITY - msg_bytes) bad = 1'b1;

    if (bad) begin
      clear_shadow(1'b0);
      v.status    = ST_REJECTED;
      v.wr_offset = '0;
      v.msg_size  = '0;
    end else begin
      v.wr_offset = msg_bytes;
      msg_bytes   = msg_bytes + chk[OUT_W-1:0];
      frm_done    = frm_done + chk[OUT_W-1:0];
      v.status    = ST_ACCEPTED;
      if (frm_done == frm_len) begin
        frm_open = 1'b0;
        if (frm_fin) begin
          msg_open = 1'b0;
          v.status = ST_COMPLETE;
        end
      end
      v.msg_size = msg_bytes;
    end
    pending_verdicts.push_back(v);
  endtask

  // ---------------------------------------------------------------------
  // Beat builders and the sender
  // ---------------------------------------------------------------------

  function automatic wfr_item_t mk_push(input logic [7:0] kind, input logic fin,
                                        input int unsigned len,
                                        input int unsigned off,
                                        input int unsigned chk,
                                        input logic present);
    wfr_item_t it;
    it.opcode                   = OP_PUSH;
    it.frame_type               = kind;
    it.fin                      = fin;
    it.frame_len                = LEN_W'(len);
    it.chunk_off                = LEN_W'(off);
    it.chunk_length             = LEN_W'(chk);
    it.data_present             = present;
    it.allow_first_continuation = 1'($urandom_range(1));
    return it;
  endfunction

  // Reset beat; the unused fields carry random junk.
  function automatic wfr_item_t mk_reset(input logic allow);
    wfr_item_t it;
    it.opcode                   = OP_RESET;
    it.frame_type               = 8'($urandom);
    it.fin                      = 1'($urandom_range(1));
    it.frame_len                = LEN_W'($urandom);
    it.chunk_off                = LEN_W'($urandom);
    it.chunk_length             = LEN_W'($urandom);
    it.data_present             = 1'($urandom_range(1));
    it.allow_first_continuation = allow;
    return it;
  endfunction

  // Entered and left at a falling edge. Valid stays high on exit so that
  // back-to-back beats never drop it; callers that pause lower it.
  task automatic send_beat(input wfr_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid                    <= 1'b1;
    in_opcode                   <= it.opcode;
    in_frame_type               <= it.frame_type;
    in_fin                      <= it.fin;
    in_frame_len                <= it.frame_len;
    in_chunk_off                <= it.chunk_off;
    in_chunk_length             <= it.chunk_length;
    in_data_present             <= it.data_present;
    in_allow_first_continuation <= it.allow_first_continuation;
    do @(posedge clk); while (in_stall);
    track_reassembly(it);
    beats_sent++;
    @(negedge clk);
  endtask

  // Sender holds off until every queued result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_directed_cases();
    // continuation with no permission after power-up reset
    send_beat(mk_push(KIND_CONTINUATION, 1'b1, 8, 0, 8, 1'b1));
    // permitted continuation opens the first message, split in two chunks
    send_beat(mk_reset(1'b1));
    send_beat(mk_push(KIND_CONTINUATION, 1'b0, 100, 0, 40, 1'b1));
    send_beat(mk_push(KIND_CONTINUATION, 1'b0, 100, 40, 60, 1'b1));
    // binary start while a message is open
    send_beat(mk_push(KIND_BINARY, 1'b1, 10, 0, 10, 1'b1));
    // full-capacity message in one chunk, then one byte over
    send_beat(mk_push(KIND_BINARY, 1'b1, 4096, 0, 4096, 1'b1));
    send_beat(mk_push(KIND_BINARY, 1'b1, 4097, 0, 0, 1'b1));
    // data pointer absent with nonzero length
    send_beat(mk_push(KIND_BINARY, 1'b1, 5, 0, 5, 1'b0));
    // empty frames: absent data is fine at zero length
    send_beat(mk_push(KIND_BINARY, 1'b0, 0, 0, 0, 1'b0));
    send_beat(mk_push(KIND_CONTINUATION, 1'b1, 0, 0, 0, 1'b1));
    // bounds: offset past end, chunk past end, empty chunk mid-frame
    send_beat(mk_push(KIND_BINARY, 1'b1, 10, 11, 0, 1'b1));
    send_beat(mk_push(KIND_BINARY, 1'b1, 10, 0, 11, 1'b1));
    send_beat(mk_push(KIND_BINARY, 1'b1, 10, 0, 0, 1'b1));
    // frame start while a frame is in progress
    send_beat(mk_push(KIND_BINARY, 1'b0, 20, 0, 5, 1'b1));
    send_beat(mk_push(KIND_BINARY, 1'b0, 20, 0, 5, 1'b1));
    // middle chunks that disagree with the open frame: fin, offset, type
    send_beat(mk_push(KIND_BINARY, 1'b0, 20, 0, 5, 1'b1));
    send_beat(mk_push(KIND_BINARY, 1'b1, 20, 5, 5, 1'b1));
    send_beat(mk_push(KIND_BINARY, 1'b0, 20, 0, 5, 1'b1));
    send_beat(mk_push(KIND_BINARY, 1'b0, 20, 6, 5, 1'b1));
    send_beat(mk_push(KIND_BINARY, 1'b0, 20, 0, 5, 1'b1));
    send_beat(mk_push(KIND_CONTINUATION, 1'b0, 20, 5, 5, 1'b1));
    // middle chunk with no open frame; unknown frame type
    send_beat(mk_push(KIND_CONTINUATION, 1'b0, 10, 3, 3, 1'b1));
    send_beat(mk_push(8'hFF, 1'b1, 4, 0, 4, 1'b1));
    // message overflow on the second frame
    send_beat(mk_push(KIND_BINARY, 1'b0, 4000, 0, 4000, 1'b1));
    send_beat(mk_push(KIND_CONTINUATION, 1'b1, 97, 0, 97, 1'b1));
    // all-ones fields, then reset without permission
    send_beat(mk_push(8'hFF, 1'b1, '1, '1, '1, 1'b1));
    send_beat(mk_reset(1'b0));
    send_beat(mk_push(KIND_CONTINUATION, 1'b0, 0, 0, 0, 1'b0));
  endtask

  // One message of 1..4 frames, each split into chunks; a few chunks get
  // one field broken.
  task automatic send_message();
    int          frames;
    int          len;
    int          off;
    int          chk;
    int          left;
    logic [7:0]  kind;
    logic        last;
    wfr_item_t   it;
    frames = $urandom_range(1, 4);
    for (int f = 0; f < frames; f++) begin
      if (f == 0)
        kind = ($urandom_range(99) < 85) ? KIND_BINARY : KIND_CONTINUATION;
      else
        kind = ($urandom_range(99) < 95) ? KIND_CONTINUATION : KIND_BINARY;
      len  = ($urandom_range(99) < 8) ? $urandom_range(0, 4096) : $urandom_range(0, 48);
      last = (f == frames - 1);
      off  = 0;
      do begin
        left = len - off;
        if (left == 0)
          chk = 0;
        else
          chk = ($urandom_range(99) < 40) ? left : $urandom_range(1, left);
        it = mk_push(kind, last, len, off, chk,
                     (chk == 0) ? 1'($urandom_range(1)) : 1'b1);
        if ($urandom_range(99) < 4) begin
          case ($urandom_range(5))
            0: it.fin = ~it.fin;
            1: it.chunk_off = it.chunk_off + LEN_W'($urandom_range(1, 3));
            2: it.frame_len = it.frame_len + LEN_W'(1);
            3: it.frame_type = 8'($urandom);
            4: it.data_present = 1'b0;
            default: it.chunk_length = it.chunk_length + LEN_W'(1);
          endcase
        end
        send_beat(it);
        off += chk;
      end while (off < len);
    end
  endtask

  task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
    int unsigned stop_at;
    int          pick;
    wfr_item_t   it;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_beat(mk_reset(1'($urandom_range(1))));
      end else if (pick < 18) begin
        // raw noise over the full field ranges; half the time offset and length are narrowed
        it = mk_push(8'($urandom), 1'($urandom_range(1)), $urandom, $urandom, $urandom,
                     1'($urandom_range(1)));
        if ($urandom_range(1)) begin
          it.chunk_off = LEN_W'($urandom_range(0, 64));
          it.frame_len = LEN_W'($urandom_range(0, 64));
        end
        send_beat(it);
      end else begin
        send_message();
      end
      if ($urandom_range(39) == 0) wait_for_results();
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d wr %0d size %0d",
                 $time, out_status, out_write_offset, out_message_size);
        mismatches++;
      end else begin
        v = pending_verdicts.pop_front();
        if (out_status !== v.status) begin
          $display("%0t: status expected %0d actual %0d", $time, v.status, out_status);
          mismatches++;
        end
        if (out_write_offset !== v.wr_offset) begin
          $display("%0t: write_offset expected %0d actual %0d",
                   $time, v.wr_offset, out_write_offset);
          mismatches++;
        end
        if (out_message_size !== v.msg_size) begin
          $display("%0t: message_size expected %0d actual %0d",
                   $time, v.msg_size, out_message_size);
          mismatches++;
        end
      end
    end
  end

  // Counts cycles where no beat moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_websocket_fragment_reassembly_check NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_n                       = 1'b0;
    in_valid                    = 1'b0;
    in_opcode                   = OP_PUSH;
    in_frame_type               = '0;
    in_fin                      = 1'b0;
    in_frame_len                = '0;
    in_chunk_off                = '0;
    in_chunk_length             = '0;
    in_data_present             = 1'b0;
    in_allow_first_continuation = 1'b0;
    out_stall                   = 1'b0;
    beats_sent                  = 0;
    mismatches                  = 0;
    quiet_cycles                = 0;
    send_idle_pct               = 21;
    recv_idle_pct               = 47;
    clear_shadow(1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    wait_for_results();
    // sender sparse / receiver busy, then swapped, then both at full rate
    test_random_traffic(410, 21, 47);
    test_random_traffic(410, 47, 21);
    test_random_traffic(410, 0, 0);
    wait_for_results();
    repeat (4) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb_websocket_fragment_reassembly_check OK");
    end else begin
      $display("tb_websocket_fragment_reassembly_check NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wfr_pkg.sv
src/wfr_check.sv
src/websocket_fragment_reassembly_check.sv
dv/tb_websocket_fragment_reassembly_check.sv
